>>> rtl/core/qppt_pkg.sv
package qppt_pkg;

    localparam int QUAT_W     = 16;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam quat_t  QUAT_ONE  = quat_t'(1 <<< (QUAT_W - 2));
    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W - 1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W - 1){1'b0}}});

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAT_X   = 3'd0,
        CFG_QUAT_Y   = 3'd1,
        CFG_QUAT_Z   = 3'd2,
        CFG_QUAT_W   = 3'd3,
        CFG_ORIGIN_X = 3'd4,
        CFG_ORIGIN_Y = 3'd5,
        CFG_ORIGIN_Z = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_FROM_POSE = 1'b0,
        OP_INTO_POSE = 1'b1
    } opcode_t;

endpackage

>>> rtl/core/qppt_cfg_if.sv
interface qppt_cfg_if;
    import qppt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/qppt_point_if.sv
interface qppt_point_if;
    import qppt_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    coord_t  point_x;
    coord_t  point_y;
    coord_t  point_z;

    modport source (output valid, output opcode, output point_x, output point_y,
                    output point_z, input ready);
    modport sink   (input valid, input opcode, input point_x, input point_y,
                    input point_z, output ready);
endinterface

>>> rtl/core/qppt_result_if.sv
interface qppt_result_if;
    import qppt_pkg::*;

    logic   valid;
    logic   ready;
    coord_t result_x;
    coord_t result_y;
    coord_t result_z;
    logic   overflow;

    modport source (output valid, output result_x, output result_y, output result_z,
                    output overflow, input ready);
    modport sink   (input valid, input result_x, input result_y, input result_z,
                    input overflow, output ready);
endinterface

>>> rtl/core/quaternion_pose_point_transform.sv
// Rigid pose transform of 3D points in a five-stage pipeline: input register, operand
// (p or p - t), nine 26x33 multipliers, row sums, round/saturate into the output register.
// One point is accepted per cycle while the results are taken, each result passing through
// every stage register in order; backpressure stalls every stage without loss. The pose
// registers are always ready; the rotation matrix is rebuilt from them in two registered
// steps, so the user must present a point from the edge after a pose write on, not at the
// same edge as the write; the block itself does not enforce this.
module quaternion_pose_point_transform (
    input  logic          clk,
    input  logic          rst_n,
    qppt_cfg_if.sink      cfg,
    qppt_point_if.sink    points,
    qppt_result_if.source results
);
    import qppt_pkg::*;

    localparam int QPROD_W   = 2 * QUAT_W;
    localparam int MAT_RAW_W = QPROD_W + 3;
    localparam int MAT_SHIFT = 8;
    localparam int MAT_W     = MAT_RAW_W - MAT_SHIFT - 1;
    localparam int MAT_FRAC  = 2 * (QUAT_W - 2) - MAT_SHIFT;
    localparam int OPND_W    = COORD_W + 1;
    localparam int PROD_W    = MAT_W + OPND_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int HI_W      = ACC_W - (MAT_FRAC + COORD_W - 1);

    typedef logic signed [QPROD_W-1:0]   qprod_t;
    typedef logic signed [MAT_RAW_W-1:0] mat_raw_t;
    typedef logic signed [MAT_W-1:0]     mat_t;
    typedef logic signed [OPND_W-1:0]    opnd_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [ACC_W-1:0]     acc_t;

    typedef struct packed {
        coord_t value;
        logic   sat;
    } sat_t;

    localparam mat_raw_t MAT_ONE  = mat_raw_t'(1) <<< (2 * (QUAT_W - 2));
    localparam mat_raw_t MAT_HALF = mat_raw_t'(1) <<< (MAT_SHIFT - 1);
    localparam acc_t     RND_HALF = acc_t'(1) <<< (MAT_FRAC - 1);

    function automatic mat_t mat_round(input mat_raw_t v);
        mat_raw_t s;
        s = v + MAT_HALF;
        return s[MAT_SHIFT+MAT_W-1:MAT_SHIFT];
    endfunction

    // 1.0 - 2.0 * (a + b)
    function automatic mat_t diag_entry(input qprod_t a, input qprod_t b);
        mat_raw_t s;
        s = MAT_ONE - ((mat_raw_t'(a) + mat_raw_t'(b)) <<< 1);
        return mat_round(s);
    endfunction

    // 2.0 * (a +/- b)
    function automatic mat_t off_entry(input qprod_t a, input qprod_t b, input logic neg);
        mat_raw_t s;
        s = neg ? (mat_raw_t'(a) - mat_raw_t'(b)) : (mat_raw_t'(a) + mat_raw_t'(b));
        return mat_round(s <<< 1);
    endfunction

    function automatic sat_t round_sat(input acc_t a);
        acc_t            r;
        logic [HI_W-1:0] hi;
        sat_t            res;
        r  = a + RND_HALF;
        hi = r[ACC_W-1:MAT_FRAC+COORD_W-1];
        if ((&hi) || !(|hi))
        begin
            res.value = r[MAT_FRAC+COORD_W-1:MAT_FRAC];
            res.sat   = 1'b0;
        end
        else
        begin
            res.value = r[ACC_W-1] ? COORD_MIN : COORD_MAX;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

    // ---------------- pose registers ----------------
    quat_t  quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;
    coord_t origin_reg [3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg    <= '0;
            quat_y_reg    <= '0;
            quat_z_reg    <= '0;
            quat_w_reg    <= QUAT_ONE;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_QUAT_X:   quat_x_reg    <= cfg.data[QUAT_W-1:0];
                CFG_QUAT_Y:   quat_y_reg    <= cfg.data[QUAT_W-1:0];
                CFG_QUAT_Z:   quat_z_reg    <= cfg.data[QUAT_W-1:0];
                CFG_QUAT_W:   quat_w_reg    <= cfg.data[QUAT_W-1:0];
                CFG_ORIGIN_X: origin_reg[0] <= cfg.data[COORD_W-1:0];
                CFG_ORIGIN_Y: origin_reg[1] <= cfg.data[COORD_W-1:0];
                CFG_ORIGIN_Z: origin_reg[2] <= cfg.data[COORD_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------- rotation matrix, two registered steps ----------------
    qprod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    mat_t   mat_reg [3][3];

    always_ff @(posedge clk)
    begin
        xx_reg <= quat_x_reg * quat_x_reg;
        yy_reg <= quat_y_reg * quat_y_reg;
        zz_reg <= quat_z_reg * quat_z_reg;
        xy_reg <= quat_x_reg * quat_y_reg;
        xz_reg <= quat_x_reg * quat_z_reg;
        yz_reg <= quat_y_reg * quat_z_reg;
        wx_reg <= quat_w_reg * quat_x_reg;
        wy_reg <= quat_w_reg * quat_y_reg;
        wz_reg <= quat_w_reg * quat_z_reg;
    end

    always_ff @(posedge clk)
    begin
        mat_reg[0][0] <= diag_entry(yy_reg, zz_reg);
        mat_reg[0][1] <= off_entry(xy_reg, wz_reg, 1'b1);
        mat_reg[0][2] <= off_entry(xz_reg, wy_reg, 1'b0);
        mat_reg[1][0] <= off_entry(xy_reg, wz_reg, 1'b0);
        mat_reg[1][1] <= diag_entry(xx_reg, zz_reg);
        mat_reg[1][2] <= off_entry(yz_reg, wx_reg, 1'b1);
        mat_reg[2][0] <= off_entry(xz_reg, wy_reg, 1'b1);
        mat_reg[2][1] <= off_entry(yz_reg, wx_reg, 1'b0);
        mat_reg[2][2] <= diag_entry(xx_reg, yy_reg);
    end

    // ---------------- point pipeline ----------------
    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, res_valid_reg;
    logic    s1_ready, s2_ready, s3_ready, s4_ready, res_ready;
    opcode_t s1_op_reg, s2_op_reg;
    coord_t  s1_pt_reg [3];
    opnd_t   s2_opnd_reg [3];
    coord_t  s2_bias_reg [3];
    coord_t  s3_bias_reg [3];
    prod_t   s3_prod_reg [3][3];
    acc_t    s4_acc_reg [3];
    coord_t  res_reg [3];
    logic    res_ovf_reg;

    opnd_t   opnd_next [3];
    coord_t  bias_next [3];
    prod_t   prod_next [3][3];
    acc_t    acc_next [3];
    sat_t    sat_next [3];

    assign res_ready     = !res_valid_reg || results.ready;
    assign s4_ready      = !s4_valid_reg || res_ready;
    assign s3_ready      = !s3_valid_reg || s4_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign points.ready  = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)  s1_valid_reg  <= points.valid;
            if (s2_ready)  s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)  s3_valid_reg  <= s2_valid_reg;
            if (s4_ready)  s4_valid_reg  <= s3_valid_reg;
            if (res_ready) res_valid_reg <= s4_valid_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (s1_op_reg == OP_INTO_POSE)
            begin
                opnd_next[j] = opnd_t'(s1_pt_reg[j]) - opnd_t'(origin_reg[j]);
                bias_next[j] = '0;
            end
            else
            begin
                opnd_next[j] = opnd_t'(s1_pt_reg[j]);
                bias_next[j] = origin_reg[j];
            end
        end
    end

    // into the pose frame uses the transpose
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (s2_op_reg == OP_INTO_POSE)
                    prod_next[i][j] = prod_t'(mat_reg[j][i]) * prod_t'(s2_opnd_reg[j]);
                else
                    prod_next[i][j] = prod_t'(mat_reg[i][j]) * prod_t'(s2_opnd_reg[j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = acc_t'(s3_prod_reg[i][0]) + acc_t'(s3_prod_reg[i][1])
                        + acc_t'(s3_prod_reg[i][2]) + (acc_t'(s3_bias_reg[i]) <<< MAT_FRAC);
            sat_next[i] = round_sat(s4_acc_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_op_reg    <= points.opcode;
            s1_pt_reg[0] <= points.point_x;
            s1_pt_reg[1] <= points.point_y;
            s1_pt_reg[2] <= points.point_z;
        end
        if (s2_ready)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_opnd_reg <= opnd_next;
            s2_bias_reg <= bias_next;
        end
        if (s3_ready)
        begin
            s3_prod_reg <= prod_next;
            s3_bias_reg <= s2_bias_reg;
        end
        if (s4_ready)
            s4_acc_reg <= acc_next;
        if (res_ready)
        begin
            res_reg[0]  <= sat_next[0].value;
            res_reg[1]  <= sat_next[1].value;
            res_reg[2]  <= sat_next[2].value;
            res_ovf_reg <= sat_next[0].sat | sat_next[1].sat | sat_next[2].sat;
        end
    end

    assign results.valid    = res_valid_reg;
    assign results.result_x = res_reg[0];
    assign results.result_y = res_reg[1];
    assign results.result_z = res_reg[2];
    assign results.overflow = res_ovf_reg;

endmodule

>>> rtl/core/qppt_checker.sv
module qppt_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input qppt_pkg::coord_t out_x,
    input qppt_pkg::coord_t out_y,
    input qppt_pkg::coord_t out_z,
    input logic            out_overflow
);
    import qppt_pkg::*;

    localparam int          MAX_PENDING = 5;
    localparam logic [3:0]  PEND_MAX    = 4'(MAX_PENDING);

    logic [3:0] pending_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 4'(in_xfer) - 4'(out_xfer);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z) && $stable(out_overflow))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result with no point outstanding");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_MAX)
        else $error("more points in flight than pipeline stages");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_overflow |->
            out_x == COORD_MAX || out_x == COORD_MIN || out_y == COORD_MAX ||
            out_y == COORD_MIN || out_z == COORD_MAX || out_z == COORD_MIN)
        else $error("overflow flagged with no saturated coordinate");

endmodule

bind quaternion_pose_point_transform qppt_checker u_qppt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (points.valid),
    .in_ready     (points.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_x        (results.result_x),
    .out_y        (results.result_y),
    .out_z        (results.result_z),
    .out_overflow (results.overflow)
);

>>> tb/quaternion_pose_point_transform_checker.sv
`timescale 1ns / 1ps

module quaternion_pose_point_transform_checker
    import qppt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    qppt_cfg_if    cfg,
    qppt_point_if  points,
    qppt_result_if results,
    output int     fail_count,
    output int     pending
);

    localparam int              MAT_SHIFT  = 8;
    localparam int              MAT_FRAC   = 20;
    localparam longint signed   UNIT_Q28   = 64'sd1 <<< 28;
    localparam longint signed   UNIT_Q20   = 64'sd1 <<< MAT_FRAC;
    localparam longint signed   HALF_Q20   = 64'sd1 <<< (MAT_FRAC - 1);

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   overflow;
    } point_result_t;

    // shadow of the pose registers
    quat_t  quat_x, quat_y, quat_z, quat_w;
    coord_t origin_x, origin_y, origin_z;

    point_result_t predicted_points[$];

    function automatic longint signed round_entry(input longint signed q28);
        return (q28 + (64'sd1 <<< (MAT_SHIFT - 1))) >>> MAT_SHIFT;
    endfunction

    function automatic point_result_t predict_point(input opcode_t op, input coord_t px,
                                                    input coord_t py, input coord_t pz);
        longint signed qx, qy, qz, qw, r;
        longint signed m[3][3];
        longint signed p[3];
        longint signed t[3];
        longint signed v[3];
        coord_t        c[3];
        logic          ovf;
        int            i, j;
        point_result_t res;
        qx = longint'(quat_x);
        qy = longint'(quat_y);
        qz = longint'(quat_z);
        qw = longint'(quat_w);
        p[0] = longint'(px);
        p[1] = longint'(py);
        p[2] = longint'(pz);
        t[0] = longint'(origin_x);
        t[1] = longint'(origin_y);
        t[2] = longint'(origin_z);

        // matrix entries exact in Q.28, rounded to Q.20
        m[0][0] = round_entry(UNIT_Q28 - 2 * (qy * qy + qz * qz));
        m[0][1] = round_entry(2 * (qx * qy - qw * qz));
        m[0][2] = round_entry(2 * (qx * qz + qw * qy));
        m[1][0] = round_entry(2 * (qx * qy + qw * qz));
        m[1][1] = round_entry(UNIT_Q28 - 2 * (qx * qx + qz * qz));
        m[1][2] = round_entry(2 * (qy * qz - qw * qx));
        m[2][0] = round_entry(2 * (qx * qz - qw * qy));
        m[2][1] = round_entry(2 * (qy * qz + qw * qx));
        m[2][2] = round_entry(UNIT_Q28 - 2 * (qx * qx + qy * qy));

        ovf = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            if (op == OP_FROM_POSE)
            begin
                v[i] = t[i] * UNIT_Q20;
                for (j = 0; j < 3; j++)
                    v[i] = v[i] + m[i][j] * p[j];
            end
            else
            begin
                // transpose: walk down column i
                v[i] = 0;
                for (j = 0; j < 3; j++)
                    v[i] = v[i] + m[j][i] * (p[j] - t[j]);
            end
            r = (v[i] + HALF_Q20) >>> MAT_FRAC;
            if (r > longint'(COORD_MAX))
            begin
                r   = longint'(COORD_MAX);
                ovf = 1'b1;
            end
            else if (r < longint'(COORD_MIN))
            begin
                r   = longint'(COORD_MIN);
                ovf = 1'b1;
            end
            c[i] = coord_t'(r);
        end
        res.x        = c[0];
        res.y        = c[1];
        res.z        = c[2];
        res.overflow = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_result_t want;
        if (!rst_n)
        begin
            quat_x     = '0;
            quat_y     = '0;
            quat_z     = '0;
            quat_w     = QUAT_ONE;
            origin_x   = '0;
            origin_y   = '0;
            origin_z   = '0;
            fail_count = 0;
            predicted_points.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_QUAT_X:   quat_x   = quat_t'(cfg.data[QUAT_W-1:0]);
                    CFG_QUAT_Y:   quat_y   = quat_t'(cfg.data[QUAT_W-1:0]);
                    CFG_QUAT_Z:   quat_z   = quat_t'(cfg.data[QUAT_W-1:0]);
                    CFG_QUAT_W:   quat_w   = quat_t'(cfg.data[QUAT_W-1:0]);
                    CFG_ORIGIN_X: origin_x = coord_t'(cfg.data);
                    CFG_ORIGIN_Y: origin_y = coord_t'(cfg.data);
                    CFG_ORIGIN_Z: origin_z = coord_t'(cfg.data);
                    default:      ;
                endcase
            end

            if (points.valid && points.ready)
                predicted_points.push_back(predict_point(points.opcode, points.point_x,
                                                         points.point_y, points.point_z));

            if (results.valid && results.ready)
            begin
                if (predicted_points.size() == 0)
                    report_mismatch("unexpected result x", longint'(results.result_x), 0);
                else
                begin
                    want = predicted_points.pop_front();
                    if (results.result_x !== want.x)
                        report_mismatch("result_x", longint'(results.result_x),
                                        longint'(want.x));
                    if (results.result_y !== want.y)
                        report_mismatch("result_y", longint'(results.result_y),
                                        longint'(want.y));
                    if (results.result_z !== want.z)
                        report_mismatch("result_z", longint'(results.result_z),
                                        longint'(want.z));
                    if (results.overflow !== want.overflow)
                        report_mismatch("overflow", longint'(results.overflow),
                                        longint'(want.overflow));
                end
            end
            pending <= predicted_points.size();
        end
    end

endmodule

>>> tb/quaternion_pose_point_transform_tb.sv
`timescale 1ns / 1ps

module quaternion_pose_point_transform_tb;
    import qppt_pkg::*;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 12;
    localparam int CALM_PHASE      = 5;
    localparam int IDLE_PCT        = 25;
    localparam int DRAIN_CYCLES    = 8;
    localparam int POSE_SETTLE     = 4;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    qppt_cfg_if    cfg_bus();
    qppt_point_if  point_bus();
    qppt_result_if result_bus();

    quaternion_pose_point_transform dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .points  (point_bus),
        .results (result_bus)
    );

    quaternion_pose_point_transform_checker transform_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .points     (point_bus),
        .results    (result_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result backpressure
    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic coord_t pick_coord();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return coord_t'($urandom);
        if (sel < 85)
            return coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        case ($urandom_range(0, 3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic send_point(input opcode_t op, input coord_t px, input coord_t py,
                              input coord_t pz);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            point_bus.valid <= 1'b0;
            @(posedge clk);
        end
        point_bus.valid   <= 1'b1;
        point_bus.opcode  <= op;
        point_bus.point_x <= px;
        point_bus.point_y <= py;
        point_bus.point_z <= pz;
        @(posedge clk);
        while (!point_bus.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        point_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // upper bits of quaternion writes carry junk, the block keeps only 16
    task automatic set_pose(input quat_t qx, input quat_t qy, input quat_t qz, input quat_t qw,
                            input coord_t ox, input coord_t oy, input coord_t oz);
        drain_results();
        write_reg(CFG_QUAT_X, {16'($urandom), qx});
        write_reg(CFG_QUAT_Y, {16'($urandom), qy});
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_QUAT_Z, {16'($urandom), qz});
        write_reg(CFG_QUAT_W, {16'($urandom), qw});
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        cfg_bus.valid <= 1'b0;
        repeat (POSE_SETTLE) @(posedge clk);
    endtask

    task automatic random_pose(input int kind);
        quat_t  q[4];
        coord_t o[3];
        int     k;
        for (k = 0; k < 4; k++)
            q[k] = (kind == 1) ? quat_t'($urandom)
                               : quat_t'(int'($urandom_range(0, 32768)) - 16384);
        if (kind == 3)
        begin
            for (k = 0; k < 4; k++)
                q[k] = '0;
            k = $urandom_range(0, 3);
            q[k] = $urandom_range(0, 1) ? QUAT_ONE : -QUAT_ONE;
        end
        for (k = 0; k < 3; k++)
        begin
            case (kind)
                0:       o[k] = coord_t'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
                1:       o[k] = coord_t'($urandom);
                2:       o[k] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                default: o[k] = pick_coord();
            endcase
        end
        set_pose(q[0], q[1], q[2], q[3], o[0], o[1], o[2]);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n             <= 1'b0;
        calm              <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= '0;
        cfg_bus.data      <= '0;
        point_bus.valid   <= 1'b0;
        point_bus.opcode  <= OP_FROM_POSE;
        point_bus.point_x <= '0;
        point_bus.point_y <= '0;
        point_bus.point_z <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity pose straight out of reset
        send_point(OP_FROM_POSE, 0, 0, 0);
        send_point(OP_FROM_POSE, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(OP_FROM_POSE, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(OP_INTO_POSE, COORD_MAX, COORD_MIN, 1);
        send_point(OP_INTO_POSE, -1, 0, 65536);

        // quarter turn about z, origin at the top of the range on z
        set_pose(0, 0, 11585, 11585, 65536, -196608, COORD_MAX);
        send_point(OP_FROM_POSE, 65536, 0, 0);
        send_point(OP_INTO_POSE, 65536, 131072, -65536);
        send_point(OP_FROM_POSE, COORD_MAX, 0, COORD_MAX);
        send_point(OP_INTO_POSE, COORD_MIN, COORD_MIN, COORD_MIN);

        // most negative quaternion, far from unit length
        set_pose(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(OP_FROM_POSE, 65536, 65536, 65536);
        send_point(OP_INTO_POSE, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(OP_FROM_POSE, -1, -1, -1);

        set_pose(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, -1, -1, -1);
        send_point(OP_FROM_POSE, 1, 2, 3);
        send_point(OP_INTO_POSE, COORD_MIN, COORD_MAX, 0);

        // x at one with a negated w register, a quaternion not of unit length
        set_pose(QUAT_ONE, 0, 0, -QUAT_ONE, 327680, -65536, 12345);
        send_point(OP_FROM_POSE, 65536, 131072, 196608);
        send_point(OP_INTO_POSE, 65536, 131072, 196608);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            random_pose(phase % 4);
            calm <= (phase == CALM_PHASE);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_point(opcode_t'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                           pick_coord());
        end

        calm <= 1'b0;
        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
